// ===== rtl/core/drs_pkg.sv =====
// Shared types, constants and helper function of the disk request scheduler.
package drs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYL_W       = 16;
    localparam int SUM_W       = 21;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [SUM_W-1:0] TOTAL_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SSTF = 2'd1;
    localparam logic [1:0] MODE_SCAN = 2'd2;
    localparam logic [1:0] MODE_LOOK = 2'd3;

    localparam logic [1:0] DIR_ANY  = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_MODE     = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_SWEEP_UP = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_LAST_CYL = 4'h8;

    localparam logic OP_SET_HEAD = 1'b0;

    // Best candidate found so far, carried from cell to cell.
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
        logic [CYL_W-1:0]   span;
        logic [CYL_W-1:0]   cyl;
    } drs_best_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic [CYL_W-1:0]   head;
        logic [1:0]         dir;
        logic               fcfs;
        logic               clear;
        logic               load;
        logic [IDX_W-1:0]   load_idx;
        logic [CYL_W-1:0]   load_cyl;
        logic               mark;
        logic [IDX_W-1:0]   mark_idx;
    } drs_bcast_t;

    function automatic logic [CYL_W-1:0] gap(input logic [CYL_W-1:0] a,
                                             input logic [CYL_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/core/drs_cell.sv =====
// One queue slot: holds a request and compares it against the passing best candidate.
module drs_cell
    import drs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  drs_bcast_t       bcast,
    input  drs_best_t        best_in,
    output drs_best_t        best_out
);

    logic [CYL_W-1:0] cyl_reg;
    logic             occ_reg;
    logic             served_reg;
    drs_best_t        best_reg;
    drs_best_t        best_next;

    logic [CYL_W-1:0] span;
    logic             dir_ok;
    logic             eligible;
    logic             take;

    always_comb
    begin
        span = gap(cyl_reg, bcast.head);
        case (bcast.dir)
            DIR_UP:   dir_ok = (cyl_reg >= bcast.head);
            DIR_DOWN: dir_ok = (cyl_reg <= bcast.head);
            default:  dir_ok = 1'b1;
        endcase
        eligible = occ_reg && !served_reg && dir_ok;
        // Strict comparison keeps the lowest index on a tie.
        take = eligible && (!best_in.valid || (!bcast.fcfs && (span < best_in.span)));
        if (take)
        begin
            best_next.valid = 1'b1;
            best_next.idx   = idx;
            best_next.span  = span;
            best_next.cyl   = cyl_reg;
        end
        else
        begin
            best_next = best_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= 1'b0;
            served_reg <= 1'b0;
            best_reg   <= '0;
        end
        else
        begin
            best_reg <= best_next;
            if (bcast.clear)
            begin
                occ_reg    <= 1'b0;
                served_reg <= 1'b0;
            end
            else if (bcast.load && (bcast.load_idx == idx))
            begin
                occ_reg    <= 1'b1;
                served_reg <= 1'b0;
            end
            else if (bcast.mark && (bcast.mark_idx == idx))
            begin
                served_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bcast.load && (bcast.load_idx == idx))
        begin
            cyl_reg <= bcast.load_cyl;
        end
    end

    assign best_out = best_reg;

endmodule

// ===== rtl/core/drs_ctrl.sv =====
// Sequencer: loads the batch, steps through the schedule and registers the results.
module drs_ctrl
    import drs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             operation,
    input  logic [CYL_W-1:0] cylinder,
    input  logic             last,
    input  logic [1:0]       mode_i,
    input  logic             sweep_up_i,
    input  logic [CYL_W-1:0] last_cyl_i,
    input  drs_best_t        best_i,
    output drs_bcast_t       bcast,
    output logic             busy,
    output logic             result_strobe,
    output logic [CYL_W-1:0] visit_cylinder,
    output logic [SUM_W-1:0] movement_total,
    output logic             end_of_run
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_FINAL  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CYL_W-1:0] head_reg, head_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             up_reg, up_next;
    logic             edge_done_reg, edge_done_next;
    logic             retry_reg, retry_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [CYL_W-1:0] pend_cyl_reg, pend_cyl_next;
    logic [SUM_W-1:0] pend_sum_reg, pend_sum_next;
    logic             strobe_reg, strobe_next;
    logic [CYL_W-1:0] vcyl_reg, vcyl_next;
    logic [SUM_W-1:0] vsum_reg, vsum_next;
    logic             end_reg, end_next;

    logic             prod;
    logic [CYL_W-1:0] prod_cyl;
    logic [SUM_W-1:0] prod_sum;
    logic [CYL_W-1:0] edge_cyl;
    logic             before_edge;
    logic [CYL_W-1:0] move_target;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] mv_sum;
    logic [CNT_W-1:0] count_after;
    logic             is_sweep;

    always_comb
    begin
        is_sweep    = (mode_i inside {MODE_SCAN, MODE_LOOK});
        edge_cyl    = up_reg ? last_cyl_i : '0;
        before_edge = up_reg ? (head_reg < edge_cyl) : (head_reg > edge_cyl);
        move_target = ((state_reg == S_DECIDE) && best_i.valid) ? best_i.cyl : edge_cyl;
        sum_ext     = {1'b0, sum_reg} + (SUM_W+1)'(gap(head_reg, move_target));
        // TOTAL_MAX is all ones, so a carry out means the total saturates.
        mv_sum      = sum_ext[SUM_W] ? TOTAL_MAX : sum_ext[SUM_W-1:0];
        count_after = ((operation != OP_SET_HEAD) && (count_reg < CNT_W'(QUEUE_DEPTH)))
                      ? count_reg + 1'b1 : count_reg;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        count_next      = count_reg;
        left_next       = left_reg;
        head_next       = head_reg;
        sum_next        = sum_reg;
        up_next         = up_reg;
        edge_done_next  = edge_done_reg;
        retry_next      = retry_reg;
        pend_valid_next = pend_valid_reg;
        pend_cyl_next   = pend_cyl_reg;
        pend_sum_next   = pend_sum_reg;
        strobe_next     = 1'b0;
        vcyl_next       = vcyl_reg;
        vsum_next       = vsum_reg;
        end_next        = end_reg;

        prod     = 1'b0;
        prod_cyl = head_reg;
        prod_sum = sum_reg;

        bcast.head     = head_reg;
        bcast.dir      = is_sweep ? (up_reg ? DIR_UP : DIR_DOWN) : DIR_ANY;
        bcast.fcfs     = (mode_i == MODE_FCFS);
        bcast.clear    = 1'b0;
        bcast.load     = 1'b0;
        bcast.load_idx = count_reg[IDX_W-1:0];
        bcast.load_cyl = cylinder;
        bcast.mark     = 1'b0;
        bcast.mark_idx = best_i.idx;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_SET_HEAD)
                    begin
                        head_next = cylinder;
                    end
                    else if (count_reg < CNT_W'(QUEUE_DEPTH))
                    begin
                        bcast.load = 1'b1;
                    end
                    count_next = count_after;
                    if (last)
                    begin
                        sum_next       = '0;
                        prod           = 1'b1;
                        prod_cyl       = (operation == OP_SET_HEAD) ? cylinder : head_reg;
                        prod_sum       = '0;
                        left_next      = count_after;
                        up_next        = sweep_up_i;
                        edge_done_next = 1'b0;
                        retry_next     = 1'b0;
                        cnt_next       = '0;
                        state_next     = (count_after != '0) ? S_SEARCH : S_FINAL;
                    end
                end
            end
            S_SEARCH:
            begin
                // The candidate passes through the register of every cell on its way to the chain end.
                if (cnt_reg == IDX_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                cnt_next = '0;
                if (best_i.valid)
                begin
                    bcast.mark = 1'b1;
                    left_next  = left_reg - 1'b1;
                    head_next  = best_i.cyl;
                    sum_next   = mv_sum;
                    prod       = 1'b1;
                    prod_cyl   = best_i.cyl;
                    prod_sum   = mv_sum;
                    retry_next = 1'b0;
                    state_next = (left_reg == CNT_W'(1)) ? S_FINAL : S_SEARCH;
                end
                else if (is_sweep && !retry_reg)
                begin
                    // Nothing left in this direction: visit the edge once for
                    // SCAN, then reverse and search again.
                    if ((mode_i == MODE_SCAN) && !edge_done_reg && before_edge)
                    begin
                        head_next = edge_cyl;
                        sum_next  = mv_sum;
                        prod      = 1'b1;
                        prod_cyl  = edge_cyl;
                        prod_sum  = mv_sum;
                    end
                    edge_done_next = 1'b1;
                    up_next        = !up_reg;
                    retry_next     = 1'b1;
                    state_next     = S_SEARCH;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if ((mode_i == MODE_SCAN) && !edge_done_reg && (count_reg != '0) && before_edge)
                begin
                    head_next = edge_cyl;
                    sum_next  = mv_sum;
                    prod      = 1'b1;
                    prod_cyl  = edge_cyl;
                    prod_sum  = mv_sum;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                strobe_next     = 1'b1;
                vcyl_next       = pend_cyl_reg;
                vsum_next       = pend_sum_reg;
                end_next        = 1'b1;
                pend_valid_next = 1'b0;
                bcast.clear     = 1'b1;
                count_next      = '0;
                left_next       = '0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Each result is held as pending until the next one is produced, so that the final one can carry end_of_run.
        if (prod)
        begin
            if (pend_valid_reg)
            begin
                strobe_next = 1'b1;
                vcyl_next   = pend_cyl_reg;
                vsum_next   = pend_sum_reg;
                end_next    = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_cyl_next   = prod_cyl;
            pend_sum_next   = prod_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            count_reg      <= '0;
            left_reg       <= '0;
            head_reg       <= '0;
            sum_reg        <= '0;
            up_reg         <= 1'b0;
            edge_done_reg  <= 1'b0;
            retry_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            count_reg      <= count_next;
            left_reg       <= left_next;
            head_reg       <= head_next;
            sum_reg        <= sum_next;
            up_reg         <= up_next;
            edge_done_reg  <= edge_done_next;
            retry_reg      <= retry_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_cyl_reg <= pend_cyl_next;
        pend_sum_reg <= pend_sum_next;
        vcyl_reg     <= vcyl_next;
        vsum_reg     <= vsum_next;
        end_reg      <= end_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_strobe  = strobe_reg;
    assign visit_cylinder = vcyl_reg;
    assign movement_total = vsum_reg;
    assign end_of_run     = end_reg;

    a_left_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= count_reg)
        else $error("requests left to serve exceed the stored count");

    a_plain_modes_find: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) && ((mode_i == MODE_FCFS) || (mode_i == MODE_SSTF))
        |-> best_i.valid)
        else $error("search found no request although some are unserved");

    a_strobe_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(pend_valid_reg))
        else $error("result transfer without a pending result");

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && end_reg) |-> (state_reg == S_IDLE) && !pend_valid_reg)
        else $error("final result transfer while the run is still active");

endmodule

// ===== rtl/core/disk_request_scheduler_unit.sv =====
// Top level of the disk request scheduler: register port, sequencer and cell chain.
//
//  Channel   | Signals                                         | Transfer
//  ----------+-------------------------------------------------+---------------------------------
//  request   | start, busy, operation, cylinder, last          | start high while busy low
//  result    | result_strobe, visit_cylinder, movement_total,  | the cycle result_strobe is high
//            | end_of_run                                      |
//  registers | psel, penable, pwrite, paddr, pwdata, prdata,   | psel, penable, pwrite, pready
//            | pready                                          |
//
// Loading accepts one item per cycle while busy is low. Each scheduled visit takes a search in
// which the candidate travels the whole cell chain; the single sweep reversal of a scan or look
// run adds one more search. The final result transfer comes in the same cycle in which busy
// falls. Reset clears the queue and all control state at once; no clearing pass.
// Results cannot be stalled by the receiver, so the block never waits on the result side.
module disk_request_scheduler_unit
    import drs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic [CYL_W-1:0]  cylinder,
    input  logic              last,
    output logic              result_strobe,
    output logic [CYL_W-1:0]  visit_cylinder,
    output logic [SUM_W-1:0]  movement_total,
    output logic              end_of_run,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [1:0]       mode_reg;
    logic             sweep_up_reg;
    logic [CYL_W-1:0] last_cyl_reg;
    logic             wr_en;

    drs_bcast_t       bcast;
    drs_best_t        chain [0:QUEUE_DEPTH];

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_FCFS;
            sweep_up_reg <= 1'b0;
            last_cyl_reg <= {CYL_W{1'b1}};
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_MODE:     mode_reg     <= pwdata[1:0];
                ADDR_SWEEP_UP: sweep_up_reg <= pwdata[0];
                ADDR_LAST_CYL: last_cyl_reg <= pwdata[CYL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_MODE:     prdata = DATA_W'(mode_reg);
            ADDR_SWEEP_UP: prdata = DATA_W'(sweep_up_reg);
            ADDR_LAST_CYL: prdata = DATA_W'(last_cyl_reg);
            default:       prdata = '0;
        endcase
    end

    drs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .operation      (operation),
        .cylinder       (cylinder),
        .last           (last),
        .mode_i         (mode_reg),
        .sweep_up_i     (sweep_up_reg),
        .last_cyl_i     (last_cyl_reg),
        .best_i         (chain[QUEUE_DEPTH]),
        .bcast          (bcast),
        .busy           (busy),
        .result_strobe  (result_strobe),
        .visit_cylinder (visit_cylinder),
        .movement_total (movement_total),
        .end_of_run     (end_of_run)
    );

    // The chain head starts every search with no candidate.
    assign chain[0] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        drs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (IDX_W'(i)),
            .bcast    (bcast),
            .best_in  (chain[i]),
            .best_out (chain[i+1])
        );
    end

endmodule
